/* hw/rtl/kmf_pkg.sv */
// Package for the keypad message framer with rate limiting.
// Holds payload structs, result codes and register indexes; depends on nothing.
package kmf_pkg;

   typedef struct packed {
      logic        func;
      logic [7:0]  key;
      logic [31:0] tick_seconds;
      logic [31:0] uptime_now;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  feedback;
      logic [7:0]  msg_key;
      logic [4:0]  key_index;
      logic        last;
      logic [7:0]  grace_count;
      logic        grace_changed;
      logic [7:0]  attempts_left;
      logic [31:0] next_process_seconds;
   } rsp_type;

   localparam logic       FUNC_KEY  = 1'b0;
   localparam logic       FUNC_TICK = 1'b1;

   localparam logic [1:0] KIND_FEEDBACK = 2'd0;
   localparam logic [1:0] KIND_MSG_KEY  = 2'd1;
   localparam logic [1:0] KIND_TICK     = 2'd2;

   localparam logic [1:0] FB_ACCEPTED = 2'd0;
   localparam logic [1:0] FB_REJECTED = 2'd1;
   localparam logic [1:0] FB_INVALID  = 2'd2;

   localparam logic [2:0] REG_START_KEY   = 3'd0;
   localparam logic [2:0] REG_END_KEY     = 3'd1;
   localparam logic [2:0] REG_STOP_LENGTH = 3'd2;
   localparam logic [2:0] REG_BUCKET_MAX  = 3'd3;
   localparam logic [2:0] REG_REFILL      = 3'd4;
   localparam logic [2:0] REG_GRACE_INIT  = 3'd5;
   localparam logic [2:0] REG_TIMEOUT     = 3'd6;
   localparam logic [2:0] REG_IDLE_INTVL  = 3'd7;

endpackage

/* hw/rtl/keypad_message_framer_rate_limit.sv */
// Top level of the keypad message framer with token-bucket rate limiting.
// Depends on kmf_pkg for the payload structs, codes and register indexes.
//
// Usage: each request carries a key press or a time tick on req_data and is
// taken when req_valid is high and req_stall is low. Results leave on
// rsp_data under rsp_valid/rsp_stall; the final result of a request has last
// set. Registers are written through csr_valid/csr_ready/csr_index/csr_data;
// the user must do so only while the block is idle, which the block does not
// enforce; csr_ready is always high. A key press passes through the execute
// state before its result is offered. A finished valid message emits its body
// keys from the body memory, each read in the read state and then offered in
// the output state, where a stalled key waits until it is taken.
// A tick runs a restoring divider (a load step and eight steps) for the
// attempt count and offers its status result after the divide and tick states.
// One request is worked at a time; req_stall is high until its last result
// has been taken, and a stalled result holds its payload.
// Reset loads the register defaults and clears the framing and bucket
// control state; the body memory needs no clearing.
module keypad_message_framer_rate_limit #(
   parameter int MAX_BODY_KEYS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kmf_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kmf_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import kmf_pkg::*;

   localparam int AW = (MAX_BODY_KEYS > 1) ? $clog2(MAX_BODY_KEYS) : 1;
   localparam int LW = $clog2(MAX_BODY_KEYS + 1);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_EXEC = 7'b0000010,
      S_DIV  = 7'b0000100,
      S_TICK = 7'b0001000,
      S_RESP = 7'b0010000,
      S_RD   = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   state_type   state_ff;

   logic [7:0]  start_key_ff, end_key_ff, stop_len_ff, bmax_ff, grace0_ff;
   logic [11:0] refill_ff;
   logic [31:0] timeout_ff, idle_ff;

   req_type     req_ff;
   rsp_type     rsp_ff;
   logic [19:0] credit_ff, maxc_ff, gthr_ff;
   logic        loaded_ff;
   logic [7:0]  stored_grace_ff;
   logic [LW-1:0] len_ff, emit_len_ff, idx_ff;
   logic        too_long_ff, open_ff, pending_ff;
   logic [31:0] last_act_ff;

   logic [19:0] rem_ff, dvs_ff;
   logic [7:0]  quo_ff;
   logic [3:0]  step_ff;
   logic        sat_ff;

   logic [7:0]  body_mem [0:MAX_BODY_KEYS-1];
   logic [7:0]  mem_rd_ff;

   logic        mem_we;
   logic [AW-1:0] mem_wa;

   logic [32:0] sum_in;
   logic [19:0] credit_tick_in;
   logic        limited;
   logic [LW-1:0] len_inc_in;
   logic        tl_in;
   logic [7:0]  attempts_in, grace_in;
   logic [31:0] la_in;
   logic        drop_in;
   rsp_type     tick_rsp_in;

   function automatic rsp_type fb_rsp(input logic [1:0] fb);
      rsp_type r;
      r          = '0;
      r.kind     = KIND_FEEDBACK;
      r.feedback = fb;
      r.last     = 1'b1;
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP) || (state_ff == S_OUT);

   always_comb begin
      rsp_data = rsp_ff;
      if (state_ff == S_OUT) begin
         rsp_data = '0;
         rsp_data.kind      = KIND_MSG_KEY;
         rsp_data.msg_key   = mem_rd_ff;
         rsp_data.key_index = 5'(idx_ff);
         rsp_data.last      = ((idx_ff + LW'(1)) == emit_len_ff);
      end
   end

   always_comb begin
      sum_in = {13'd0, credit_ff} + {1'b0, req_ff.tick_seconds};
      credit_tick_in = (sum_in >= {13'd0, maxc_ff}) ? maxc_ff : sum_in[19:0];
      limited = (bmax_ff != 8'd0) && (credit_ff < {8'd0, refill_ff});
      tl_in = too_long_ff;
      len_inc_in = len_ff;
      mem_we = 1'b0;
      mem_wa = len_ff[AW-1:0];
      if (len_ff < LW'(MAX_BODY_KEYS)) begin
         len_inc_in = len_ff + LW'(1);
      end else begin
         tl_in = 1'b1;
      end
      if ((state_ff == S_EXEC) && (req_ff.func == FUNC_KEY) && !limited &&
          (req_ff.key != start_key_ff) && open_ff && (req_ff.key != end_key_ff) &&
          (len_ff < LW'(MAX_BODY_KEYS))) begin
         mem_we = 1'b1;
      end
   end

   always_comb begin
      if (bmax_ff == 8'd0) begin
         attempts_in = 8'd0;
      end else if (refill_ff == 12'd0 || sat_ff) begin
         attempts_in = 8'd255;
      end else begin
         attempts_in = quo_ff;
      end
      if (bmax_ff == 8'd0) begin
         grace_in = 8'd0;
      end else if (credit_ff >= gthr_ff) begin
         grace_in = grace0_ff;
      end else begin
         grace_in = attempts_in;
      end
      la_in = pending_ff ? req_ff.uptime_now : last_act_ff;
      drop_in = open_ff && ((req_ff.uptime_now - la_in) > timeout_ff);
      tick_rsp_in = '0;
      tick_rsp_in.kind          = KIND_TICK;
      tick_rsp_in.last          = 1'b1;
      tick_rsp_in.grace_count   = grace_in;
      tick_rsp_in.grace_changed = (grace_in != stored_grace_ff);
      tick_rsp_in.attempts_left = attempts_in;
      tick_rsp_in.next_process_seconds = (open_ff && !drop_in) ? 32'd1 : idle_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         body_mem[mem_wa] <= req_ff.key;
      end
      if (state_ff == S_RD) begin
         mem_rd_ff <= body_mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         start_key_ff    <= 8'd42;
         end_key_ff      <= 8'd35;
         stop_len_ff     <= 8'd0;
         bmax_ff         <= 8'd128;
         refill_ff       <= 12'd720;
         grace0_ff       <= 8'd6;
         timeout_ff      <= 32'd16;
         idle_ff         <= 32'd20;
         credit_ff       <= '0;
         loaded_ff       <= 1'b0;
         stored_grace_ff <= 8'd6;
         len_ff          <= '0;
         too_long_ff     <= 1'b0;
         open_ff         <= 1'b0;
         pending_ff      <= 1'b0;
         last_act_ff     <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_START_KEY:   start_key_ff <= csr_data[7:0];
               REG_END_KEY:     end_key_ff   <= csr_data[7:0];
               REG_STOP_LENGTH: stop_len_ff  <= csr_data[7:0];
               REG_BUCKET_MAX:  bmax_ff      <= csr_data[7:0];
               REG_REFILL:      refill_ff    <= csr_data[11:0];
               REG_GRACE_INIT:  grace0_ff    <= csr_data[7:0];
               REG_TIMEOUT:     timeout_ff   <= csr_data;
               REG_IDLE_INTVL:  idle_ff      <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  req_ff  <= req_data;
                  maxc_ff <= 20'(bmax_ff * refill_ff);
                  gthr_ff <= 20'(grace0_ff * refill_ff);
                  if (!loaded_ff) begin
                     stored_grace_ff <= grace0_ff;
                     credit_ff       <= 20'(grace0_ff * refill_ff);
                     loaded_ff       <= 1'b1;
                  end
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (req_ff.func == FUNC_TICK) begin
                  credit_ff <= credit_tick_in;
                  step_ff   <= 4'd0;
                  state_ff  <= S_DIV;
               end else begin
                  pending_ff <= 1'b1;
                  priority if (limited) begin
                     rsp_ff   <= fb_rsp(FB_REJECTED);
                     state_ff <= S_RESP;
                  end else if (req_ff.key == start_key_ff) begin
                     open_ff     <= 1'b1;
                     len_ff      <= '0;
                     too_long_ff <= 1'b0;
                     rsp_ff      <= fb_rsp(FB_ACCEPTED);
                     state_ff    <= S_RESP;
                  end else if (!open_ff) begin
                     rsp_ff   <= fb_rsp(FB_REJECTED);
                     state_ff <= S_RESP;
                  end else if ((req_ff.key == end_key_ff) ||
                               ((stop_len_ff != 8'd0) &&
                                (8'(len_inc_in) >= stop_len_ff))) begin
                     if ((req_ff.key == end_key_ff) ? (len_ff != '0 && !too_long_ff)
                                                    : (len_inc_in != '0 && !tl_in)) begin
                        emit_len_ff <= (req_ff.key == end_key_ff) ? len_ff : len_inc_in;
                        idx_ff      <= '0;
                        state_ff    <= S_RD;
                     end else begin
                        rsp_ff   <= fb_rsp(FB_INVALID);
                        state_ff <= S_RESP;
                     end
                     if (bmax_ff != 8'd0 && credit_ff >= {8'd0, refill_ff}) begin
                        credit_ff <= credit_ff - {8'd0, refill_ff};
                     end
                     open_ff     <= 1'b0;
                     len_ff      <= '0;
                     too_long_ff <= 1'b0;
                  end else begin
                     len_ff      <= len_inc_in;
                     too_long_ff <= tl_in;
                     rsp_ff      <= fb_rsp(FB_ACCEPTED);
                     state_ff    <= S_RESP;
                  end
               end
            end
            S_DIV: begin
               if (step_ff == 4'd0) begin
                  sat_ff <= (credit_ff >= {refill_ff, 8'd0});
                  rem_ff <= credit_ff;
                  dvs_ff <= {1'b0, refill_ff, 7'd0};
                  quo_ff <= '0;
               end else begin
                  if (rem_ff >= dvs_ff) begin
                     rem_ff <= rem_ff - dvs_ff;
                     quo_ff <= {quo_ff[6:0], 1'b1};
                  end else begin
                     quo_ff <= {quo_ff[6:0], 1'b0};
                  end
                  dvs_ff <= dvs_ff >> 1;
               end
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'd8) begin
                  state_ff <= S_TICK;
               end
            end
            S_TICK: begin
               stored_grace_ff <= grace_in;
               if (open_ff) begin
                  last_act_ff <= la_in;
                  pending_ff  <= 1'b0;
               end
               if (drop_in) begin
                  open_ff     <= 1'b0;
                  len_ff      <= '0;
                  too_long_ff <= 1'b0;
               end
               rsp_ff   <= tick_rsp_in;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            S_RD: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  if ((idx_ff + LW'(1)) == emit_len_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + LW'(1);
                     state_ff <= S_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
